// ----- hdl/gf2_poly_modular_exponent_unit_assert.svh -----
// Assertion macros used by the port-level checker
`ifndef GF2_POLY_MODULAR_EXPONENT_UNIT_ASSERT_SVH
`define GF2_POLY_MODULAR_EXPONENT_UNIT_ASSERT_SVH
// check that an implication holds at every clock edge outside reset
`define GPME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// check that an implication holds in the next cycle
`define GPME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/gpme_pkg.sv -----
// Package: command and status types shared by the controller and datapath
`default_nettype none
package gpme_pkg;
	localparam int unsigned W = 128;
	localparam int unsigned HW = 64;
	localparam int unsigned DW = 7;
	localparam int unsigned IDXW = 3;
	localparam logic [IDXW-1:0] REG_POLY_LO = 3'd0;
	localparam logic [IDXW-1:0] REG_POLY_HI = 3'd1;
	localparam logic [IDXW-1:0] REG_INV_LO = 3'd2;
	localparam logic [IDXW-1:0] REG_INV_HI = 3'd3;
	localparam logic [IDXW-1:0] REG_DEGREE = 3'd4;

	// multiplier operand selects
	typedef enum logic [1:0] {
		SRC_ACC_SQ = 2'd0,
		SRC_SQ_SQ = 2'd1,
		SRC_Q_INV = 2'd2,
		SRC_Q_POLY = 2'd3
	} src_t;

	typedef struct packed {
		logic load;
		logic mul_start;
		src_t src;
		logic cap_in;
		logic cap_q;
		logic wr_acc;
		logic wr_sq;
		logic shift_exp;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_zero;
		logic exp_bit0;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/gpme_clmul.sv -----
// Iterative 128x128 carry-less multiplier, 8 multiplier bits per cycle
`default_nettype none
module gpme_clmul (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [gpme_pkg::W-1:0] a,
	input wire logic [gpme_pkg::W-1:0] b,
	output logic done,
	output logic [2*gpme_pkg::W-1:0] prod
);
	localparam int unsigned STEP = 8;
	localparam int unsigned NCYC = gpme_pkg::W / STEP;
	localparam int unsigned CW = $clog2(NCYC + 1);

	logic [2*gpme_pkg::W-1:0] a_q;
	logic [gpme_pkg::W-1:0] b_q;
	logic [2*gpme_pkg::W-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [2*gpme_pkg::W-1:0] part;

	always_comb begin
		part = '0;
		for (int i = 0; i < STEP; i++) begin
			if (b_q[i]) begin
				part = part ^ (a_q << i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NCYC - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= {{gpme_pkg::W{1'b0}}, a};
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q ^ part;
			a_q <= a_q << STEP;
			b_q <= b_q >> STEP;
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ----- hdl/gpme_datapath.sv -----
// Datapath: operand registers, shared multiplier, Barrett reduction steps
`default_nettype none
module gpme_datapath #(
	parameter int unsigned FIELD_BITS = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire gpme_pkg::cmd_t cmd,
	output gpme_pkg::sts_t sts,
	input wire logic [gpme_pkg::W-1:0] base,
	input wire logic [gpme_pkg::W-1:0] expo,
	input wire logic [gpme_pkg::W-1:0] poly,
	input wire logic [gpme_pkg::W-1:0] inv,
	input wire logic [gpme_pkg::DW-1:0] degree,
	output logic [gpme_pkg::W-1:0] acc
);
	localparam logic [gpme_pkg::W-1:0] FMASK =
		(FIELD_BITS >= 128) ? {gpme_pkg::W{1'b1}} : ((128'd1 << FIELD_BITS) - 128'd1);

	logic [gpme_pkg::W-1:0] acc_q, sq_q, exp_q, ma, mb, q_q;
	logic [2*gpme_pkg::W-1:0] in_q, prod, shr;
	logic mdone;

	gpme_clmul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(ma), .b(mb), .done(mdone), .prod(prod)
	);

	always_comb begin
		case (cmd.src)
			gpme_pkg::SRC_ACC_SQ: begin ma = acc_q; mb = sq_q; end
			gpme_pkg::SRC_SQ_SQ: begin ma = sq_q; mb = sq_q; end
			gpme_pkg::SRC_Q_INV: begin ma = q_q; mb = inv; end
			gpme_pkg::SRC_Q_POLY: begin ma = q_q; mb = poly; end
			default: begin ma = acc_q; mb = sq_q; end
		endcase
	end

	assign shr = prod >> degree;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= {{(gpme_pkg::W-1){1'b0}}, 1'b1};
			sq_q <= base & FMASK;
			exp_q <= expo;
		end else begin
			if (cmd.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
			if (cmd.wr_acc) begin
				acc_q <= (prod[gpme_pkg::W-1:0] ^ in_q[gpme_pkg::W-1:0]) & FMASK;
			end
			if (cmd.wr_sq) begin
				sq_q <= (prod[gpme_pkg::W-1:0] ^ in_q[gpme_pkg::W-1:0]) & FMASK;
			end
		end
		if (cmd.cap_in) begin
			in_q <= prod;
			q_q <= shr[gpme_pkg::W-1:0] ;
		end else if (cmd.cap_q) begin
			q_q <= shr[gpme_pkg::W-1:0];
		end
	end

	assign sts.mul_done = mdone;
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_bit0 = exp_q[0];
	assign acc = acc_q;
endmodule
`default_nettype wire

// ----- hdl/gpme_ctrl.sv -----
// Controller: sequences square-and-multiply and the Barrett steps
`default_nettype none
module gpme_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	output gpme_pkg::cmd_t cmd,
	input wire gpme_pkg::sts_t sts
);
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_NEXT = 8'b0000_0010,
		ST_MUL = 8'b0000_0100,
		ST_QINV = 8'b0000_1000,
		ST_QPOLY = 8'b0001_0000,
		ST_WB = 8'b0010_0000,
		ST_DONE = 8'b0100_0000,
		ST_QGO = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic is_sq_q;
	gpme_pkg::src_t src_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		cmd = '0;
		cmd.src = src_q;
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_NEXT: begin
				if (!sts.exp_zero) begin
					cmd.mul_start = 1'b1;
					cmd.src = sts.exp_bit0 ? gpme_pkg::SRC_ACC_SQ : gpme_pkg::SRC_SQ_SQ;
				end
			end
			ST_MUL: begin
				if (sts.mul_done) begin
					cmd.cap_in = 1'b1;
				end
			end
			// start q * INV once the first quotient is in its register
			ST_QGO: begin
				cmd.mul_start = 1'b1;
				cmd.src = gpme_pkg::SRC_Q_INV;
			end
			ST_QINV: begin
				if (sts.mul_done) begin
					cmd.cap_q = 1'b1;
				end
			end
			ST_QPOLY: begin
				cmd.mul_start = 1'b1;
				cmd.src = gpme_pkg::SRC_Q_POLY;
			end
			ST_WB: begin
				if (sts.mul_done) begin
					cmd.wr_acc = !is_sq_q;
					cmd.wr_sq = is_sq_q;
					cmd.shift_exp = is_sq_q;
					// after a multiply, start the square of the same bit
					if (!is_sq_q) begin
						cmd.mul_start = 1'b1;
						cmd.src = gpme_pkg::SRC_SQ_SQ;
					end
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			is_sq_q <= 1'b0;
			src_q <= gpme_pkg::SRC_ACC_SQ;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (sts.exp_zero) begin
						state_q <= ST_DONE;
					end else begin
						is_sq_q <= !sts.exp_bit0;
						src_q <= sts.exp_bit0 ? gpme_pkg::SRC_ACC_SQ : gpme_pkg::SRC_SQ_SQ;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: if (sts.mul_done) begin
					src_q <= gpme_pkg::SRC_Q_INV;
					state_q <= ST_QGO;
				end
				ST_QGO: state_q <= ST_QINV;
				ST_QINV: if (sts.mul_done) state_q <= ST_QPOLY;
				ST_QPOLY: begin
					src_q <= gpme_pkg::SRC_Q_POLY;
					state_q <= ST_WB;
				end
				ST_WB: if (sts.mul_done) begin
					if (is_sq_q) begin
						state_q <= ST_NEXT;
					end else begin
						// multiply done; square the same bit next
						is_sq_q <= 1'b1;
						src_q <= gpme_pkg::SRC_SQ_SQ;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/gf2_poly_modular_exponent_unit.sv -----
// Top level: GF(2) polynomial modular exponentiation unit
// One request at a time: base^exponent mod P by right-to-left square-and-multiply,
// every product reduced with Barrett reduction. All products go through one
// carry-less multiplier that retires 8 bits per cycle; each reduced product takes
// three multiplier runs. An exponent with top set bit k costs (k+1) squares plus
// one multiply per set bit, plus a decision step per bit. Exponent zero returns 1.
// Configuration registers: 0 poly_lo, 1 poly_hi, 2 inv_lo, 3 inv_hi, 4 poly_degree.
`default_nettype none
module gf2_poly_modular_exponent_unit #(
	parameter int unsigned FIELD_BITS = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [63:0] base_lo,
	input wire logic [63:0] base_hi,
	input wire logic [63:0] exponent_lo,
	input wire logic [63:0] exponent_hi,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] result_lo,
	output logic [63:0] result_hi,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [gpme_pkg::IDXW-1:0] cfg_index,
	input wire logic [63:0] cfg_data
);
	logic [63:0] poly_lo_q, poly_hi_q, inv_lo_q, inv_hi_q;
	logic [gpme_pkg::DW-1:0] degree_q;
	logic [gpme_pkg::W-1:0] acc;
	gpme_pkg::cmd_t cmd;
	gpme_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_lo_q <= '0;
			poly_hi_q <= '0;
			inv_lo_q <= '0;
			inv_hi_q <= '0;
			degree_q <= gpme_pkg::DW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				gpme_pkg::REG_POLY_LO: poly_lo_q <= cfg_data;
				gpme_pkg::REG_POLY_HI: poly_hi_q <= cfg_data;
				gpme_pkg::REG_INV_LO: inv_lo_q <= cfg_data;
				gpme_pkg::REG_INV_HI: inv_hi_q <= cfg_data;
				gpme_pkg::REG_DEGREE: degree_q <= cfg_data[gpme_pkg::DW-1:0];
				default: ;
			endcase
		end
	end

	gpme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	gpme_datapath #(.FIELD_BITS(FIELD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.base({base_hi, base_lo}), .expo({exponent_hi, exponent_lo}),
		.poly({poly_hi_q, poly_lo_q}), .inv({inv_hi_q, inv_lo_q}),
		.degree(degree_q), .acc(acc)
	);

	assign result_lo = acc[63:0];
	assign result_hi = acc[127:64];
endmodule
`default_nettype wire

// ----- hdl/gpme_checker.sv -----
// Port-level checker for the exponentiation unit, with its bind
`default_nettype none
`include "gf2_poly_modular_exponent_unit_assert.svh"
module gpme_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [63:0] result_lo,
	input wire logic [63:0] result_hi
);
	`GPME_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall, "input taken while result pending")
	`GPME_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall && !out_valid, "no work after accept")
	`GPME_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_lo) && $stable(result_hi), "stalled result changed")
	`GPME_ASSERT_NEXT(a_single_result, clk, arst_n, out_valid && !out_stall, !out_valid, "result repeated")
endmodule

bind gf2_poly_modular_exponent_unit gpme_checker u_gpme_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.result_lo(result_lo), .result_hi(result_hi)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the GF(2) polynomial modular exponentiation unit
`default_nettype none
module tb;
	localparam logic [gpme_pkg::IDXW-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned IDLE_LIMIT = 60000;

	typedef struct packed {
		logic [127:0] base;
		logic [127:0] expo;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] base_lo = '0, base_hi = '0, exponent_lo = '0, exponent_hi = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] result_lo, result_hi;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gpme_pkg::IDXW-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	gf2_poly_modular_exponent_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.base_lo(base_lo), .base_hi(base_hi),
		.exponent_lo(exponent_lo), .exponent_hi(exponent_hi),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_lo(result_lo), .result_hi(result_hi),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the configuration
	logic [127:0] mod_poly = '0;
	logic [127:0] barrett_inv = '0;
	logic [6:0] mod_degree = 7'd1;

	request_t pending_requests[$];
	logic [127:0] expected_powers[$];
	int unsigned fails = 0;
	int unsigned idle_cycles = 0;
	logic in_fire = 1'b0;
	logic quiet = 1'b0;
	logic sender_hold = 1'b0;
	logic long_hold_req = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned long_hold_left = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [255:0] clmul128(logic [127:0] a, logic [127:0] b);
		logic [255:0] r;
		r = '0;
		for (int i = 0; i < 128; i++)
			if (b[i])
				r ^= {128'd0, a} << i;
		return r;
	endfunction

	function automatic logic [127:0] barrett_reduce(logic [255:0] prod);
		logic [255:0] t;
		logic [127:0] q;
		t = prod >> mod_degree;
		q = t[127:0];
		t = clmul128(q, barrett_inv) >> mod_degree;
		q = t[127:0];
		t = clmul128(q, mod_poly);
		return t[127:0] ^ prod[127:0];
	endfunction

	function automatic logic [127:0] poly_pow_mod(logic [127:0] base, logic [127:0] expo);
		logic [127:0] acc, sq, e;
		acc = 128'd1;
		sq = base;
		e = expo;
		for (int i = 0; i < 128; i++) begin
			if (e == '0)
				break;
			if (e[0])
				acc = barrett_reduce(clmul128(acc, sq));
			sq = barrett_reduce(clmul128(sq, sq));
			e = e >> 1;
		end
		return acc;
	endfunction

	// floor(x^(2d) / p) by long division
	function automatic logic [127:0] barrett_const(logic [127:0] p, int d);
		logic [255:0] rem;
		logic [127:0] quo;
		rem = 256'd1 << (2 * d);
		quo = '0;
		for (int i = 2 * d; i >= d; i--)
			if (rem[i]) begin
				quo[i - d] = 1'b1;
				rem ^= {128'd0, p} << (i - d);
			end
		return quo;
	endfunction

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		logic [127:0] want;
		in_fire <= in_valid && !in_stall;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gpme_pkg::REG_POLY_LO: mod_poly[63:0] = cfg_data;
				gpme_pkg::REG_POLY_HI: mod_poly[127:64] = cfg_data;
				gpme_pkg::REG_INV_LO: barrett_inv[63:0] = cfg_data;
				gpme_pkg::REG_INV_HI: barrett_inv[127:64] = cfg_data;
				gpme_pkg::REG_DEGREE: mod_degree = cfg_data[6:0];
				default: ;
			endcase
		end
		if (in_valid && !in_stall)
			expected_powers.push_back(poly_pow_mod({base_hi, base_lo},
				{exponent_hi, exponent_lo}));
		if (out_valid && !out_stall) begin
			if (expected_powers.size() == 0) begin
				$error("unexpected result %h_%h", result_hi, result_lo);
				fails++;
			end else begin
				want = expected_powers.pop_front();
				if (result_lo !== want[63:0]) begin
					$error("result_lo expected %h got %h", want[63:0], result_lo);
					fails++;
				end
				if (result_hi !== want[127:64]) begin
					$error("result_hi expected %h got %h", want[127:64], result_hi);
					fails++;
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		request_t r;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() == 0 || sender_hold) begin
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap_left <= $urandom_range(0, 14);
				in_valid <= 1'b0;
			end else begin
				r = pending_requests.pop_front();
				base_lo <= r.base[63:0];
				base_hi <= r.base[127:64];
				exponent_lo <= r.expo[63:0];
				exponent_hi <= r.expo[127:64];
				in_valid <= 1'b1;
			end
		end
	end

	// result stall
	always @(negedge clk) begin
		if (long_hold_req && long_hold_left == 0) begin
			long_hold_left <= 2500;
			out_stall <= 1'b1;
		end else if (long_hold_left > 1) begin
			long_hold_left <= long_hold_left - 1;
			out_stall <= 1'b1;
		end else if (long_hold_left == 1) begin
			long_hold_left <= long_hold_left - 1;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic cfg_write(logic [gpme_pkg::IDXW-1:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_modulus(logic [127:0] p, logic [127:0] inv, logic [6:0] d);
		cfg_write(gpme_pkg::REG_POLY_LO, p[63:0]);
		cfg_write(gpme_pkg::REG_POLY_HI, p[127:64]);
		cfg_write(gpme_pkg::REG_INV_LO, inv[63:0]);
		cfg_write(gpme_pkg::REG_INV_HI, inv[127:64]);
		cfg_write(gpme_pkg::REG_DEGREE, {57'd0, d});
	endtask

	// random monic polynomial of degree d with its Barrett constant
	task automatic random_modulus(int d);
		logic [127:0] p;
		p = rand128() & ((128'd1 << d) - 1);
		p[d] = 1'b1;
		set_modulus(p, barrett_const(p, d), d[6:0]);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_powers.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic push(logic [127:0] base, logic [127:0] expo);
		request_t r;
		r.base = base;
		r.expo = expo;
		pending_requests.push_back(r);
	endtask

	// mostly short exponents, a few full width, some zero
	task automatic push_random(int n);
		logic [127:0] b, e;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			b = rand128();
			if (sel < 4)
				b = '0;
			else if (sel < 8)
				b = '1;
			if (sel >= 95)
				e = rand128();
			else if (sel >= 90)
				e = '0;
			else
				e = rand128() & ((128'd1 << $urandom_range(1, 12)) - 1);
			push(b, e);
		end
	endtask

	initial begin
		logic [127:0] p;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration, applied literally
		push('1, 128'd0);
		push(rand128(), 128'd1);
		push('1, 128'd5);
		wait_drained();

		// largest degree
		random_modulus(127);
		push('0, 128'd0);
		push('0, 128'd3);
		push('1, 128'd0);
		push('1, 128'd1);
		push('1, 128'd2);
		push(rand128(), '1);
		push(rand128(), 128'd1 << 127);
		push({64'd0, 64'hffff_ffff_ffff_ffff}, {64'hffff_ffff_ffff_ffff, 64'd0});
		push(128'd1, rand128());
		push(128'd2, 128'd200);
		push_random(35);
		wait_drained();

		// smallest degree: x + 1
		set_modulus(128'd3, barrett_const(128'd3, 1), 7'd1);
		push('1, 128'd7);
		push_random(30);
		wait_drained();

		// fill the unit while results are held back
		random_modulus(64);
		long_hold_req <= 1'b1;
		push_random(40);
		@(posedge clk);
		while (long_hold_left == 0)
			@(posedge clk);
		long_hold_req <= 1'b0;
		wait_drained();

		// degree zero with a mismatched constant; unused index is ignored
		set_modulus(rand128(), rand128(), 7'd0);
		cfg_write(REG_UNUSED, {$urandom, $urandom});
		push(rand128(), 128'd3);
		push_random(20);
		wait_drained();

		// random degree, sender pauses until everything has drained
		random_modulus($urandom_range(2, 126));
		push_random(30);
		sender_hold <= 1'b0;
		@(posedge clk);
		while (pending_requests.size() > 15)
			@(posedge clk);
		sender_hold <= 1'b1;
		while (in_valid || expected_powers.size() != 0)
			@(posedge clk);
		sender_hold <= 1'b0;
		wait_drained();
		push_random(30);
		wait_drained();

		// no idling in the final stretch
		p = 128'h11b;
		set_modulus(p, barrett_const(p, 8), 7'd8);
		quiet <= 1'b1;
		push_random(90);
		wait_drained();
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
